// File: design/ebca_pkg.sv
// Shared types and constants for the eight-bit cpu alu with flags.
// Used by ebca_exec and by the top level; depends on nothing.
package ebca_pkg;

  // flag bit positions inside the 4-bit flag word
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // opcode group masks and match patterns
  localparam logic [7:0] MaskAluReg  = 8'hC0;
  localparam logic [7:0] PatAluReg   = 8'h80;
  localparam logic [7:0] MaskAluImm  = 8'hC7;
  localparam logic [7:0] PatAluImm   = 8'hC6;
  localparam logic [7:0] MaskIncDec8 = 8'hC7;
  localparam logic [7:0] PatInc8     = 8'h04;
  localparam logic [7:0] PatDec8     = 8'h05;
  localparam logic [7:0] MaskPair    = 8'hCF;
  localparam logic [7:0] PatInc16    = 8'h03;
  localparam logic [7:0] PatDec16    = 8'h0B;
  localparam logic [7:0] PatAddHl    = 8'h09;

  // single opcodes
  localparam logic [7:0] OpAddSp = 8'hE8;
  localparam logic [7:0] OpDaa   = 8'h27;
  localparam logic [7:0] OpCpl   = 8'h2F;
  localparam logic [7:0] OpScf   = 8'h37;
  localparam logic [7:0] OpCcf   = 8'h3F;

  // register field that names the accumulator
  localparam logic [2:0] RegA = 3'd7;

  // decimal adjust corrections
  localparam logic [7:0] DaaHigh  = 8'h60;
  localparam logic [7:0] DaaLow   = 8'h06;
  localparam logic [7:0] DaaLimit = 8'h99;
  localparam logic [3:0] DaaNibble = 4'd9;

  // pair slot of HL in the opcode
  localparam logic [1:0] SlotHl = 2'd2;

  // 8-bit alu operation select (opcode bits 5:3)
  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBC = 3'd3,
    ALU_AND = 3'd4,
    ALU_XOR = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CP  = 3'd7
  } alu_sel_e;

  // write-back target codes
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_BYTE = 3'd1,
    TGT_PAIR = 3'd2,
    TGT_HL   = 3'd3,
    TGT_SP   = 3'd4
  } target_e;

  // everything one instruction produces
  typedef struct packed {
    logic [7:0]  acc;
    logic [3:0]  flags;
    logic [7:0]  byte_res;
    logic [15:0] word_res;
    target_e     target;
    logic        illegal;
  } exec_res_t;

endpackage

// File: design/eight_bit_cpu_alu_with_flags_top.sv
// An item passes from the input register into the result register as
// soon as the result register is free or is being emptied.
// Throughput: one item per cycle while out_stall_i is low; input register,
// execute logic in ebca_exec, result register. Accumulator and flags update
// as an item moves from the input register into the result register.
// Reset: asynchronous, active low; clears both stage valid bits, accumulator, flags.
// Top level of the eight-bit cpu alu with flags; depends on ebca_pkg and ebca_exec.
module eight_bit_cpu_alu_with_flags_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  op_i,
  input  logic [7:0]  operand_i,
  input  logic [15:0] pair_value_i,
  input  logic [15:0] hl_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  acc_out_o,
  output logic [3:0]  flags_out_o,
  output logic [7:0]  byte_result_o,
  output logic [15:0] word_result_o,
  output logic [2:0]  write_target_o,
  output logic        illegal_o
);
  import ebca_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  op_q;
  logic [7:0]  operand_q;
  logic [15:0] pair_q;
  logic [15:0] hl_q;
  logic        out_valid_q, out_valid_d;
  exec_res_t   res_q;
  exec_res_t   res;
  logic [7:0]  acc_q;
  logic [3:0]  flags_q;
  logic        advance;
  logic        in_xfer;

  // handshake: move the input stage on when the result register is free or not stalled
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= 8'd0;
      flags_q     <= 4'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        acc_q   <= res.acc;
        flags_q <= res.flags;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= op_i;
      operand_q <= operand_i;
      pair_q    <= pair_value_i;
      hl_q      <= hl_value_i;
    end
  end

  // execute
  ebca_exec u_exec (
    .op_i        (op_q),
    .operand_i   (operand_q),
    .pair_value_i(pair_q),
    .hl_value_i  (hl_q),
    .acc_i       (acc_q),
    .flags_i     (flags_q),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign acc_out_o      = res_q.acc;
  assign flags_out_o    = res_q.flags;
  assign byte_result_o  = res_q.byte_res;
  assign word_result_o  = res_q.word_res;
  assign write_target_o = res_q.target;
  assign illegal_o      = res_q.illegal;

endmodule

// File: design/ebca_exec.sv
// Combinational execute logic: decodes one opcode and computes the new
// accumulator, flags and write-back values. Depends on ebca_pkg.
module ebca_exec (
  input  logic [7:0]          op_i,
  input  logic [7:0]          operand_i,
  input  logic [15:0]         pair_value_i,
  input  logic [15:0]         hl_value_i,
  input  logic [7:0]          acc_i,
  input  logic [3:0]          flags_i,
  output ebca_pkg::exec_res_t res_o
);
  import ebca_pkg::*;

  alu_sel_e    alu_sel;
  logic [7:0]  alu_src;
  logic        alu_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [7:0]  sub_diff;
  logic [7:0]  alu_acc;
  logic [3:0]  alu_flags;
  logic        alu_wr_acc;

  logic        is_a;
  logic [7:0]  idv;
  logic [7:0]  inc_v;
  logic [7:0]  dec_v;
  logic [16:0] hl_sum;
  logic [12:0] hl_half;
  logic [4:0]  sp_half;
  logic [8:0]  sp_carry;
  logic [7:0]  daa_a;
  logic        daa_c;

  // 8-bit alu operand and operation
  always_comb begin
    alu_sel = alu_sel_e'(op_i[5:3]);
    if (((op_i & MaskAluReg) == PatAluReg) && (op_i[2:0] == RegA)) begin
      alu_src = acc_i;
    end else begin
      alu_src = operand_i;
    end
    alu_cin = ((alu_sel == ALU_ADC) || (alu_sel == ALU_SBC)) && flags_i[FlagC];
  end

  assign add_sum  = {1'b0, acc_i} + {1'b0, alu_src} + {8'd0, alu_cin};
  assign add_half = {1'b0, acc_i[3:0]} + {1'b0, alu_src[3:0]} + {4'd0, alu_cin};
  assign sub_diff = acc_i - alu_src - {7'd0, alu_cin};

  // 8-bit alu result and flags
  always_comb begin
    alu_acc    = acc_i;
    alu_flags  = flags_i;
    alu_wr_acc = 1'b1;
    unique case (alu_sel)
      ALU_ADD, ALU_ADC: begin
        alu_acc   = add_sum[7:0];
        alu_flags = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        alu_acc    = sub_diff;
        alu_wr_acc = (alu_sel != ALU_CP);
        alu_flags  = {sub_diff == 8'd0, 1'b1,
                      {1'b0, acc_i[3:0]} < ({1'b0, alu_src[3:0]} + {4'd0, alu_cin}),
                      {1'b0, acc_i} < ({1'b0, alu_src} + {8'd0, alu_cin})};
      end
      ALU_AND: begin
        alu_acc   = acc_i & alu_src;
        alu_flags = {(acc_i & alu_src) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      ALU_XOR: begin
        alu_acc   = acc_i ^ alu_src;
        alu_flags = {(acc_i ^ alu_src) == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      ALU_OR: begin
        alu_acc   = acc_i | alu_src;
        alu_flags = {(acc_i | alu_src) == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      default: begin
        alu_acc = acc_i;
      end
    endcase
  end

  // byte inc/dec
  assign is_a  = (op_i[5:3] == RegA);
  assign idv   = is_a ? acc_i : operand_i;
  assign inc_v = idv + 8'd1;
  assign dec_v = idv - 8'd1;

  // 16-bit adds
  assign hl_sum   = {1'b0, hl_value_i} + {1'b0, pair_value_i};
  assign hl_half  = {1'b0, hl_value_i[11:0]} + {1'b0, pair_value_i[11:0]};
  assign sp_half  = {1'b0, pair_value_i[3:0]} + {1'b0, operand_i[3:0]};
  assign sp_carry = {1'b0, pair_value_i[7:0]} + {1'b0, operand_i};

  // decimal adjust
  always_comb begin
    daa_a = acc_i;
    daa_c = flags_i[FlagC];
    if (!flags_i[FlagN]) begin
      if (flags_i[FlagC] || (acc_i > DaaLimit)) begin
        daa_a = daa_a + DaaHigh;
        daa_c = 1'b1;
      end
      if (flags_i[FlagH] || (daa_a[3:0] > DaaNibble)) begin
        daa_a = daa_a + DaaLow;
      end
    end else begin
      if (flags_i[FlagC]) begin
        daa_a = daa_a - DaaHigh;
      end
      if (flags_i[FlagH]) begin
        daa_a = daa_a - DaaLow;
      end
    end
  end

  // opcode decode and result select
  always_comb begin
    res_o.acc      = acc_i;
    res_o.flags    = flags_i;
    res_o.byte_res = 8'd0;
    res_o.word_res = 16'd0;
    res_o.target   = TGT_NONE;
    res_o.illegal  = 1'b0;
    priority if (((op_i & MaskAluReg) == PatAluReg) ||
                 ((op_i & MaskAluImm) == PatAluImm)) begin
      res_o.flags = alu_flags;
      if (alu_wr_acc) begin
        res_o.acc = alu_acc;
      end
    end else if ((op_i & MaskIncDec8) == PatInc8) begin
      res_o.byte_res = inc_v;
      res_o.flags    = {inc_v == 8'd0, 1'b0, idv[3:0] == 4'hF, flags_i[FlagC]};
      res_o.target   = TGT_BYTE;
      if (is_a) begin
        res_o.acc = inc_v;
      end
    end else if ((op_i & MaskIncDec8) == PatDec8) begin
      res_o.byte_res = dec_v;
      res_o.flags    = {dec_v == 8'd0, 1'b1, idv[3:0] == 4'h0, flags_i[FlagC]};
      res_o.target   = TGT_BYTE;
      if (is_a) begin
        res_o.acc = dec_v;
      end
    end else if (((op_i & MaskPair) == PatInc16) || ((op_i & MaskPair) == PatDec16)) begin
      res_o.word_res = op_i[3] ? (pair_value_i - 16'd1) : (pair_value_i + 16'd1);
      if (op_i[5:4] < SlotHl) begin
        res_o.target = TGT_PAIR;
      end else if (op_i[5:4] == SlotHl) begin
        res_o.target = TGT_HL;
      end else begin
        res_o.target = TGT_SP;
      end
    end else if ((op_i & MaskPair) == PatAddHl) begin
      res_o.word_res = hl_sum[15:0];
      res_o.flags    = {flags_i[FlagZ], 1'b0, hl_half[12], hl_sum[16]};
      res_o.target   = TGT_HL;
    end else if (op_i == OpAddSp) begin
      res_o.word_res = pair_value_i + {{8{operand_i[7]}}, operand_i};
      res_o.flags    = {1'b0, 1'b0, sp_half[4], sp_carry[8]};
      res_o.target   = TGT_SP;
    end else if (op_i == OpDaa) begin
      res_o.acc   = daa_a;
      res_o.flags = {daa_a == 8'd0, flags_i[FlagN], 1'b0, daa_c};
    end else if (op_i == OpCpl) begin
      res_o.acc   = ~acc_i;
      res_o.flags = {flags_i[FlagZ], 1'b1, 1'b1, flags_i[FlagC]};
    end else if (op_i == OpScf) begin
      res_o.flags = {flags_i[FlagZ], 1'b0, 1'b0, 1'b1};
    end else if (op_i == OpCcf) begin
      res_o.flags = {flags_i[FlagZ], 1'b0, 1'b0, ~flags_i[FlagC]};
    end else begin
      res_o.illegal = 1'b1;
    end
  end

endmodule
